[hw/rtl/ssid_pkg.sv]
// ----------------------------------------------------------------------------
// ssid_pkg
// Shared constants and types of the sorted set insert/delete core.
// ----------------------------------------------------------------------------
package ssid_pkg;

	localparam int CAPACITY    = 64;
	localparam int KEY_WIDTH   = 32;
	localparam int CNT_W       = $clog2(CAPACITY + 1);
	localparam int COUNT_OUT_W = 7;

	typedef logic signed [KEY_WIDTH-1:0] key_t;
	typedef logic [CNT_W-1:0]            cnt_t;

	typedef enum logic [1:0] {
		OP_INSERT = 2'd0,
		OP_DELETE = 2'd1,
		OP_LOOKUP = 2'd2,
		OP_CLEAR  = 2'd3
	} op_t;

	typedef enum logic {
		S_IDLE,
		S_EVAL
	} state_t;

	// Commands broadcast to every cell of the chain.
	typedef struct packed {
		logic cmp;
		logic ins;
		logic del;
	} cell_cmd_t;

endpackage

[hw/rtl/ssid_if.sv]
// ----------------------------------------------------------------------------
// ssid_if
// Request and response channels of the sorted set core.
// ----------------------------------------------------------------------------
interface ssid_req_if
	import ssid_pkg::*;
();
	logic       valid;
	logic       ready;
	logic [1:0] kind;
	key_t       key;

	modport source (output valid, output kind, output key, input ready);
	modport sink   (input valid, input kind, input key, output ready);
endinterface

interface ssid_rsp_if
	import ssid_pkg::*;
();
	logic                   valid;
	logic                   ready;
	logic                   ok;
	logic                   refused_full;
	logic [COUNT_OUT_W-1:0] entry_count;

	modport source (output valid, output ok, output refused_full, output entry_count,
		input ready);
	modport sink   (input valid, input ok, input refused_full, input entry_count,
		output ready);
endinterface

[hw/rtl/ssid_cell.sv]
// ----------------------------------------------------------------------------
// ssid_cell
// One slot of the sorted chain: holds a key, compares it with the request
// key and takes its own, the new or a neighbor's key on an update.
// ----------------------------------------------------------------------------
module ssid_cell
	import ssid_pkg::*;
(
	input  logic      clk,
	input  cell_cmd_t cmd,
	input  key_t      cmp_key,
	input  key_t      new_key,
	input  logic      in_range,
	input  logic      left_lt,
	input  key_t      left_key,
	input  key_t      right_key,
	output key_t      key,
	output logic      lt,
	output logic      eq
);

	key_t key_q;
	logic lt_s1;
	logic eq_s1;

	always_ff @(posedge clk) begin
		if (cmd.cmp) begin
			lt_s1 <= in_range && (key_q < cmp_key);
			eq_s1 <= in_range && (key_q == cmp_key);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.ins && !lt_s1) begin
			key_q <= left_lt ? new_key : left_key;
		end else if (cmd.del && !lt_s1) begin
			key_q <= right_key;
		end
	end

	assign key = key_q;
	assign lt  = lt_s1;
	assign eq  = eq_s1;

endmodule

[hw/rtl/sorted_set_insert_delete_core.sv]
// ----------------------------------------------------------------------------
// sorted_set_insert_delete_core
// Sorted set of signed keys without duplicates, kept in a chain of cells.
//
//   channel  dir  payload                          transaction
//   req      in   kind, key                        one request
//   rsp      out  ok, refused_full, entry_count    one result per request
//
// For each request the accept edge registers every cell's compare; the update
// edge, held back while a result stalls, applies the shift and loads the result.
// A request is taken only in the idle state, even while a result waits.
// A stalled result holds the update of the following request back.
// Reset empties the set; the key cells themselves are not cleared.
// ----------------------------------------------------------------------------
module sorted_set_insert_delete_core
	import ssid_pkg::*;
(
	input logic        clk,
	input logic        arst_n,
	ssid_req_if.sink   req,
	ssid_rsp_if.source rsp
);

	state_t    state_q;
	state_t    state_d;
	cnt_t      count_q;
	op_t       kind_s1;
	key_t      key_s1;
	logic      rsp_valid_q;
	logic      ok_q;
	logic      full_q;
	logic      accept;
	logic      apply;
	logic      found;
	logic      is_full;
	cell_cmd_t cmd;

	key_t                key_w [CAPACITY];
	logic [CAPACITY-1:0] lt_w;
	logic [CAPACITY-1:0] eq_w;

	assign accept  = req.valid && req.ready;
	assign apply   = (state_q == S_EVAL) && (!rsp_valid_q || rsp.ready);
	assign found   = |eq_w;
	assign is_full = (count_q >= CNT_W'(CAPACITY));

	always_comb begin
		cmd.cmp = accept;
		cmd.ins = apply && (kind_s1 == OP_INSERT) && !found && !is_full;
		cmd.del = apply && (kind_s1 == OP_DELETE) && found;
	end

	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		logic in_range;
		logic left_lt;
		key_t left_key;
		key_t right_key;

		assign in_range = (CNT_W'(i) < count_q);

		if (i == 0) begin : g_first
			assign left_lt  = 1'b1;
			assign left_key = key_w[0];
		end else begin : g_mid
			assign left_lt  = lt_w[i-1];
			assign left_key = key_w[i-1];
		end

		if (i == CAPACITY - 1) begin : g_last
			assign right_key = key_w[i];
		end else begin : g_inner
			assign right_key = key_w[i+1];
		end

		ssid_cell u_cell (
			.clk       (clk),
			.cmd       (cmd),
			.cmp_key   (req.key),
			.new_key   (key_s1),
			.in_range  (in_range),
			.left_lt   (left_lt),
			.left_key  (left_key),
			.right_key (right_key),
			.key       (key_w[i]),
			.lt        (lt_w[i]),
			.eq        (eq_w[i])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		req.ready = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				req.ready = 1'b1;
				if (req.valid) begin
					state_d = S_EVAL;
				end
			end
			S_EVAL: begin
				if (apply) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			kind_s1 <= op_t'(req.kind);
			key_s1  <= req.key;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (apply) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
			if (apply) begin
				case (kind_s1)
					OP_INSERT: if (cmd.ins) count_q <= count_q + 1'b1;
					OP_DELETE: if (cmd.del) count_q <= count_q - 1'b1;
					OP_CLEAR:  count_q <= '0;
					default:   count_q <= count_q;
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (apply) begin
			case (kind_s1)
				OP_INSERT: begin
					ok_q   <= !found && !is_full;
					full_q <= !found && is_full;
				end
				OP_DELETE, OP_LOOKUP: begin
					ok_q   <= found;
					full_q <= 1'b0;
				end
				default: begin
					ok_q   <= 1'b1;
					full_q <= 1'b0;
				end
			endcase
		end
	end

	assign rsp.valid        = rsp_valid_q;
	assign rsp.ok           = ok_q;
	assign rsp.refused_full = full_q;
	assign rsp.entry_count  = COUNT_OUT_W'(count_q);

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(CAPACITY))
		else $error("Entry count exceeds the capacity.");

	a_ins_del_excl: assert property (@(posedge clk) disable iff (!arst_n)
		!(cmd.ins && cmd.del))
		else $error("Insert and delete shift issued together.");

	a_full_not_ok: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && rsp.refused_full |-> !rsp.ok)
		else $error("A refused insert reports success.");

	a_accept_eval: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> (state_q == S_EVAL))
		else $error("An accepted request did not reach evaluation.");

	a_count_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!apply |=> $stable(count_q))
		else $error("Entry count changed without an update.");

endmodule

[sim/testbench.sv]
// ----------------------------------------------------------------------------
// testbench
// Checks the sorted set core against a behavioral copy of the key set. A
// directed list covers the extreme keys, duplicate inserts, absent deletes,
// lookups and clears. Random phases then fill the store past capacity, empty
// it again and mix all operations on small key pools. Both channels idle at
// random, and every response is compared field by field in order.
// ----------------------------------------------------------------------------
module testbench
	import ssid_pkg::*;
();

	timeunit 1ns;
	timeprecision 1ps;

	typedef struct {
		op_t  kind;
		key_t key;
		bit   hold_until_empty;
	} request_t;

	typedef struct {
		logic                   ok;
		logic                   refused_full;
		logic [COUNT_OUT_W-1:0] entry_count;
	} outcome_t;

	logic clk = 1'b0;
	logic arst_n;

	ssid_req_if req_ch ();
	ssid_rsp_if rsp_ch ();

	sorted_set_insert_delete_core i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	request_t requests_to_send[$];
	outcome_t set_outcomes[$];
	key_t     key_pool[$];
	key_t     held_keys[CAPACITY];
	int       held_count = 0;
	int       n_sent = 0;
	int       n_recv = 0;
	int       failures = 0;
	int       send_wait = 0;
	int       recv_wait = 0;
	int       send_quiet = 0;
	int       recv_quiet = 0;
	bit       hold_next = 1'b0;

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	function automatic int draw_wait(inout int quiet);
		if (quiet > 0) begin
			quiet--;
			return 0;
		end
		if ($urandom_range(0, 39) == 0) begin
			quiet = $urandom_range(10, 40);
			return 0;
		end
		return $urandom_range(0, 13);
	endfunction

	function automatic key_t random_key();
		case ($urandom_range(0, 7))
			0: begin
				case ($urandom_range(0, 3))
					0: return key_t'(32'h8000_0000);
					1: return key_t'(32'h7fff_ffff);
					2: return key_t'(0);
					default: return key_t'(-1);
				endcase
			end
			1: return key_t'($signed($urandom_range(0, 64)) - 32);
			default: return key_t'($urandom);
		endcase
	endfunction

	function automatic void apply_to_key_set(input op_t kind, input key_t key,
		output outcome_t res);
		int pos;
		int j;
		bit found;
		pos = 0;
		while (pos < held_count && held_keys[pos] < key)
			pos++;
		found = (pos < held_count) && (held_keys[pos] == key);
		res.ok = 1'b0;
		res.refused_full = 1'b0;
		case (kind)
			OP_INSERT: begin
				if (!found) begin
					if (held_count >= CAPACITY) begin
						res.refused_full = 1'b1;
					end else begin
						for (j = held_count; j > pos; j--)
							held_keys[j] = held_keys[j-1];
						held_keys[pos] = key;
						held_count++;
						res.ok = 1'b1;
					end
				end
			end
			OP_DELETE: begin
				if (found) begin
					for (j = pos; j < held_count - 1; j++)
						held_keys[j] = held_keys[j+1];
					held_count--;
					res.ok = 1'b1;
				end
			end
			OP_LOOKUP: begin
				res.ok = found;
			end
			default: begin
				held_count = 0;
				res.ok = 1'b1;
			end
		endcase
		res.entry_count = COUNT_OUT_W'(held_count);
	endfunction

	task automatic add_request(input op_t kind, input key_t key);
		request_t r;
		r.kind = kind;
		r.key = key;
		r.hold_until_empty = hold_next;
		hold_next = 1'b0;
		requests_to_send.push_back(r);
	endtask

	function automatic key_t pool_key();
		if (key_pool.size() == 0 || $urandom_range(0, 9) == 0)
			return random_key();
		return key_pool[$urandom_range(0, key_pool.size() - 1)];
	endfunction

	task automatic fill_phase();
		int n;
		int i;
		key_pool.delete();
		n = $urandom_range(64, 90);
		for (i = 0; i < n; i++)
			key_pool.push_back(random_key());
		for (i = 0; i < n; i++) begin
			add_request(OP_INSERT, key_pool[i]);
			if ($urandom_range(0, 9) == 0)
				add_request($urandom_range(0, 1) ? OP_LOOKUP : OP_DELETE, pool_key());
		end
		for (i = 0; i < 6; i++)
			add_request(OP_INSERT, pool_key());
	endtask

	task automatic empty_phase();
		int i;
		int j;
		key_t t;
		for (i = key_pool.size() - 1; i > 0; i--) begin
			j = $urandom_range(0, i);
			t = key_pool[i];
			key_pool[i] = key_pool[j];
			key_pool[j] = t;
		end
		foreach (key_pool[i]) begin
			if ($urandom_range(0, 4) != 0)
				add_request(OP_DELETE, key_pool[i]);
			if ($urandom_range(0, 3) == 0)
				add_request(OP_LOOKUP, pool_key());
		end
	endtask

	task automatic mixed_phase();
		int n;
		int i;
		int w;
		key_pool.delete();
		n = $urandom_range(8, 24);
		for (i = 0; i < n; i++)
			key_pool.push_back($urandom_range(0, 1) ?
				key_t'($signed($urandom_range(0, 40)) - 20) : random_key());
		n = $urandom_range(40, 120);
		for (i = 0; i < n; i++) begin
			w = $urandom_range(0, 99);
			if (w < 35)
				add_request(OP_INSERT, pool_key());
			else if (w < 65)
				add_request(OP_DELETE, pool_key());
			else if (w < 95)
				add_request(OP_LOOKUP, pool_key());
			else
				add_request(OP_CLEAR, random_key());
		end
	endtask

	task automatic build_stimulus();
		int directed;
		add_request(OP_LOOKUP, 0);
		add_request(OP_DELETE, 5);
		add_request(OP_INSERT, key_t'(32'h7fff_ffff));
		add_request(OP_INSERT, key_t'(32'h8000_0000));
		add_request(OP_INSERT, 0);
		add_request(OP_INSERT, -1);
		add_request(OP_INSERT, 1);
		add_request(OP_INSERT, 0);
		add_request(OP_INSERT, key_t'(32'h8000_0000));
		add_request(OP_LOOKUP, key_t'(32'h7fff_ffff));
		add_request(OP_LOOKUP, key_t'(32'h7fff_fffe));
		add_request(OP_LOOKUP, key_t'(32'h8000_0001));
		add_request(OP_DELETE, 0);
		add_request(OP_DELETE, 0);
		add_request(OP_DELETE, key_t'(32'h8000_0000));
		add_request(OP_DELETE, key_t'(32'h7fff_ffff));
		add_request(OP_CLEAR, key_t'(32'hdead_beef));
		add_request(OP_LOOKUP, -1);
		add_request(OP_INSERT, key_t'(32'hffff_ffff));
		add_request(OP_CLEAR, 0);
		add_request(OP_CLEAR, key_t'(32'h5555_aaaa));
		directed = requests_to_send.size();
		hold_next = 1'b1;
		fill_phase();
		hold_next = 1'b1;
		empty_phase();
		while (requests_to_send.size() < directed + 1850) begin
			if ($urandom_range(0, 9) == 0)
				hold_next = 1'b1;
			case ($urandom_range(0, 5))
				0: fill_phase();
				1: empty_phase();
				2: add_request(OP_CLEAR, random_key());
				default: mixed_phase();
			endcase
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		request_t item;
		outcome_t res;
		bit busy;
		if (!arst_n) begin
			req_ch.valid <= 1'b0;
			send_wait = draw_wait(send_quiet);
		end else begin
			busy = req_ch.valid;
			if (req_ch.valid && req_ch.ready) begin
				apply_to_key_set(op_t'(req_ch.kind), req_ch.key, res);
				set_outcomes.push_back(res);
				n_sent++;
				busy = 1'b0;
				send_wait = draw_wait(send_quiet);
			end
			if (!busy) begin
				if (send_wait > 0) begin
					send_wait--;
				end else if (requests_to_send.size() > 0 &&
					(!requests_to_send[0].hold_until_empty || n_recv == n_sent)) begin
					item = requests_to_send.pop_front();
					req_ch.kind <= item.kind;
					req_ch.key <= item.key;
					busy = 1'b1;
				end
			end
			req_ch.valid <= busy;
		end
	end

	always @(posedge clk or negedge arst_n) begin
		outcome_t exp_res;
		bit take;
		if (!arst_n) begin
			rsp_ch.ready <= 1'b0;
			recv_wait = draw_wait(recv_quiet);
		end else begin
			take = rsp_ch.ready;
			if (rsp_ch.valid && rsp_ch.ready) begin
				n_recv <= n_recv + 1;
				if (set_outcomes.size() == 0) begin
					$error("Response transaction arrived with no request outstanding.");
					failures++;
				end else begin
					exp_res = set_outcomes.pop_front();
					if (rsp_ch.ok !== exp_res.ok) begin
						$error("ok: expected %0d, got %0d", exp_res.ok, rsp_ch.ok);
						failures++;
					end
					if (rsp_ch.refused_full !== exp_res.refused_full) begin
						$error("refused_full: expected %0d, got %0d",
							exp_res.refused_full, rsp_ch.refused_full);
						failures++;
					end
					if (rsp_ch.entry_count !== exp_res.entry_count) begin
						$error("entry_count: expected %0d, got %0d",
							exp_res.entry_count, rsp_ch.entry_count);
						failures++;
					end
				end
				take = 1'b0;
				recv_wait = draw_wait(recv_quiet);
			end
			if (!take) begin
				if (recv_wait > 0)
					recv_wait--;
				else
					take = 1'b1;
			end
			rsp_ch.ready <= take;
		end
	end

	initial begin
		arst_n = 1'b0;
		req_ch.valid = 1'b0;
		req_ch.kind = OP_CLEAR;
		req_ch.key = '0;
		rsp_ch.ready = 1'b0;
		build_stimulus();
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		while (requests_to_send.size() != 0 || req_ch.valid || set_outcomes.size() != 0)
			@(posedge clk);
		repeat (10) @(posedge clk);
		if (failures == 0 && set_outcomes.size() == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

	initial begin
		#5_000_000;
		$display("Test completed with failures");
		$finish;
	end

endmodule
